### rtl/core/u8dec_pkg.sv
// u8dec_pkg: beat types and byte-range constants for the utf-8 stream decoder
// no dependencies; imported by utf8_stream_decoder, utf8_decode_checker and testbench
`default_nettype none

package u8dec_pkg;

  // input beat: one raw byte plus end-of-buffer flag
  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } in_beat_t;

  // result beat: one code point or one corrupt marker
  typedef struct packed {
    logic [20:0] code_point;
    logic [2:0]  byte_count;
    logic        status;
    logic        buffer_end;
  } out_beat_t;

  // status codes
  localparam logic STATUS_VALID   = 1'b0;
  localparam logic STATUS_CORRUPT = 1'b1;

  // lead byte ranges
  localparam logic [7:0] ASCII_LIMIT   = 8'h80;
  localparam logic [7:0] LEAD_MIN      = 8'hC2;
  localparam logic [7:0] LEAD2_MAX     = 8'hDF;
  localparam logic [7:0] LEAD3_MAX     = 8'hEF;
  localparam logic [7:0] LEAD_MAX      = 8'hF4;

  // continuation byte range
  localparam logic [7:0] CONT_MIN      = 8'h80;
  localparam logic [7:0] CONT_MAX      = 8'hBF;

  // leads with second-byte limits
  localparam logic [7:0] LEAD_E0       = 8'hE0;
  localparam logic [7:0] LEAD_ED       = 8'hED;
  localparam logic [7:0] LEAD_F0       = 8'hF0;
  localparam logic [7:0] LEAD_F4       = 8'hF4;
  localparam logic [7:0] E0_SECOND_MIN = 8'hA0;
  localparam logic [7:0] ED_SECOND_MAX = 8'h9F;
  localparam logic [7:0] F0_SECOND_MIN = 8'h90;
  localparam logic [7:0] F4_SECOND_MAX = 8'h8F;

  // scalar value limits
  localparam logic [20:0] SURR_MIN     = 21'h00D800;
  localparam logic [20:0] SURR_MAX     = 21'h00DFFF;
  localparam logic [20:0] CP_MAX       = 21'h10FFFF;

  // sequence lengths
  localparam logic [2:0] LEN_1 = 3'd1;
  localparam logic [2:0] LEN_2 = 3'd2;
  localparam logic [2:0] LEN_3 = 3'd3;
  localparam logic [2:0] LEN_4 = 3'd4;

endpackage

`default_nettype wire

### rtl/core/utf8_stream_decoder.sv
// utf8_stream_decoder: strict utf-8 decoder, one byte beat in, at most one result beat out
// depends on u8dec_pkg for beat types and byte-range constants
//
//   channel  | signals                              | carries
//   ---------+--------------------------------------+----------------------------------
//   octet    | octet_valid, octet_ready, octet_data | byte_in, final_byte
//   char     | char_valid, char_ready, char_data    | code_point, byte_count, status,
//            |                                      | buffer_end
//   cfg      | cfg_valid, cfg_ready, cfg_data       | relaxed_checks (always ready)
//
// one byte per cycle unless a stalled output holds back a byte with a result: a byte
// lands in the input register, is decoded against the sequence state in the next cycle
// and its result lands in the output register.
// a stalled char beat holds the output register; the input register still takes one
// more byte, and bytes that give no result keep moving while the output is full.
// synchronous reset clears valids, sequence state, discard flag and relaxed_checks.
`default_nettype none

module utf8_stream_decoder
  import u8dec_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      octet_valid,
  output logic           octet_ready,
  input  wire in_beat_t  octet_data,
  output logic           char_valid,
  input  wire logic      char_ready,
  output out_beat_t      char_data,
  input  wire logic      cfg_valid,
  output logic           cfg_ready,
  input  wire logic      cfg_data
);

  // configuration
  logic relaxed;

  // input stage
  logic     s1_valid;
  in_beat_t s1;

  // sequence state
  logic [1:0]  pending, pending_next;
  logic [2:0]  seq_len, seq_len_next;
  logic [20:0] partial, partial_next;
  logic [7:0]  lead, lead_next;
  logic        discarding, discarding_next;

  // decode outputs
  logic        has_result;
  out_beat_t   result;
  logic        do_fail;
  logic        advance;
  logic        second_byte;
  logic        second_bad;
  logic [20:0] partial_shift;
  logic [1:0]  pending_dec;

  assign cfg_ready = 1'b1;

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      relaxed <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      relaxed <= cfg_data;
    end
  end

  // input stage moves when its byte gives no result or the output slot frees
  assign advance     = s1_valid && (!has_result || !char_valid || char_ready);
  assign octet_ready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (octet_ready) begin
      s1_valid <= octet_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (octet_valid && octet_ready) begin
      s1 <= octet_data;
    end
  end

  // continuation helpers
  assign second_byte   = ({1'b0, pending} + 3'd1) == seq_len;
  assign partial_shift = {partial[14:0], s1.byte_in[5:0]};
  assign pending_dec   = pending - 2'd1;

  // second-byte limits after e0, ed, f0, f4
  always_comb begin
    second_bad = 1'b0;
    if (lead == LEAD_E0 && !relaxed && s1.byte_in < E0_SECOND_MIN) second_bad = 1'b1;
    if (lead == LEAD_ED && s1.byte_in > ED_SECOND_MAX)             second_bad = 1'b1;
    if (lead == LEAD_F0 && !relaxed && s1.byte_in < F0_SECOND_MIN) second_bad = 1'b1;
    if (lead == LEAD_F4 && s1.byte_in > F4_SECOND_MAX)             second_bad = 1'b1;
  end

  // byte decode
  always_comb begin
    pending_next    = pending;
    seq_len_next    = seq_len;
    partial_next    = partial;
    lead_next       = lead;
    discarding_next = discarding;
    has_result      = 1'b0;
    result          = '0;
    do_fail         = 1'b0;

    if (discarding) begin
      // drop bytes until the buffer ends
      if (s1.final_byte) begin
        discarding_next = 1'b0;
        pending_next    = '0;
        seq_len_next    = '0;
        partial_next    = '0;
        lead_next       = '0;
      end
    end else if (pending == 2'd0) begin
      // lead byte
      if (s1.byte_in < ASCII_LIMIT) begin
        has_result        = 1'b1;
        result.code_point = {13'd0, s1.byte_in};
        result.byte_count = LEN_1;
        result.status     = STATUS_VALID;
        result.buffer_end = s1.final_byte;
      end else if (s1.byte_in < LEAD_MIN || s1.byte_in > LEAD_MAX) begin
        do_fail = 1'b1;
      end else begin
        lead_next = s1.byte_in;
        if (s1.byte_in <= LEAD2_MAX) begin
          seq_len_next = LEN_2;
          pending_next = 2'd1;
          partial_next = {16'd0, s1.byte_in[4:0]};
        end else if (s1.byte_in <= LEAD3_MAX) begin
          seq_len_next = LEN_3;
          pending_next = 2'd2;
          partial_next = {17'd0, s1.byte_in[3:0]};
        end else begin
          seq_len_next = LEN_4;
          pending_next = 2'd3;
          partial_next = {18'd0, s1.byte_in[2:0]};
        end
        if (s1.final_byte) do_fail = 1'b1;
      end
    end else begin
      // continuation byte
      if (s1.byte_in < CONT_MIN || s1.byte_in > CONT_MAX) begin
        do_fail = 1'b1;
      end else if (second_byte && second_bad) begin
        do_fail = 1'b1;
      end else if (pending_dec == 2'd0) begin
        pending_next = '0;
        seq_len_next = '0;
        partial_next = '0;
        lead_next    = '0;
        if ((partial_shift >= SURR_MIN && partial_shift <= SURR_MAX) ||
            partial_shift > CP_MAX) begin
          do_fail = 1'b1;
        end else begin
          has_result        = 1'b1;
          result.code_point = partial_shift;
          result.byte_count = seq_len;
          result.status     = STATUS_VALID;
          result.buffer_end = s1.final_byte;
        end
      end else begin
        pending_next = pending_dec;
        partial_next = partial_shift;
        if (s1.final_byte) do_fail = 1'b1;
      end
    end

    // corrupt beat, clear the sequence, discard unless buffer ended
    if (do_fail) begin
      pending_next      = '0;
      seq_len_next      = '0;
      partial_next      = '0;
      lead_next         = '0;
      discarding_next   = !s1.final_byte;
      has_result        = 1'b1;
      result.code_point = '0;
      result.byte_count = '0;
      result.status     = STATUS_CORRUPT;
      result.buffer_end = s1.final_byte;
    end
  end

  // sequence state update
  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      seq_len    <= '0;
      partial    <= '0;
      lead       <= '0;
      discarding <= 1'b0;
    end else if (advance) begin
      pending    <= pending_next;
      seq_len    <= seq_len_next;
      partial    <= partial_next;
      lead       <= lead_next;
      discarding <= discarding_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      char_valid <= 1'b0;
    end else if (advance && has_result) begin
      char_valid <= 1'b1;
    end else if (char_ready) begin
      char_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && has_result) begin
      char_data <= result;
    end
  end

endmodule

`default_nettype wire

### tb/utf8_decode_checker.sv
// utf8_decode_checker: watches the byte, result and config channels of the decoder,
// predicts each result beat from the accepted byte beats and compares field by field
// depends on u8dec_pkg for beat types, status codes and byte-range constants
`timescale 1ns / 1ps

module utf8_decode_checker
  import u8dec_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      octet_valid,
  input  logic      octet_ready,
  input  in_beat_t  octet_data,
  input  logic      char_valid,
  input  logic      char_ready,
  input  out_beat_t char_data,
  input  logic      cfg_valid,
  input  logic      cfg_ready,
  input  logic      cfg_data,
  output int        mismatches,
  output int        pending_results
);

  // predicted decoder state
  logic        relaxed;
  logic [1:0]  pend;
  logic [2:0]  seq_len;
  logic [20:0] acc;
  logic [7:0]  lead;
  logic        dropping;

  out_beat_t   expected_chars[$];
  int          fail_count;

  task automatic close_sequence();
    pend    = '0;
    seq_len = '0;
    acc     = '0;
    lead    = '0;
  endtask

  task automatic expect_char(input logic [20:0] cp, input logic [2:0] len,
                             input logic st, input logic fin);
    out_beat_t beat;
    beat.code_point = cp;
    beat.byte_count = len;
    beat.status     = st;
    beat.buffer_end = fin;
    expected_chars.push_back(beat);
  endtask

  // one byte against the open sequence; queues at most one result
  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic        bad;
    logic [20:0] cp;
    logic [2:0]  len;
    bad = 1'b0;
    if (dropping) begin
      if (fin) begin
        dropping = 1'b0;
        close_sequence();
      end
      return;
    end
    if (pend == 2'd0) begin
      if (b < ASCII_LIMIT) begin
        expect_char({13'd0, b}, LEN_1, STATUS_VALID, fin);
        return;
      end
      if (b < LEAD_MIN || b > LEAD_MAX) begin
        bad = 1'b1;
      end else begin
        lead = b;
        if (b <= LEAD2_MAX) begin
          seq_len = LEN_2;
          acc     = {16'd0, b[4:0]};
        end else if (b <= LEAD3_MAX) begin
          seq_len = LEN_3;
          acc     = {17'd0, b[3:0]};
        end else begin
          seq_len = LEN_4;
          acc     = {18'd0, b[2:0]};
        end
        pend = 2'(seq_len - 3'd1);
        bad  = fin;
      end
    end else if (b < CONT_MIN || b > CONT_MAX) begin
      bad = 1'b1;
    end else begin
      // second byte limits after the special leads
      if ({1'b0, pend} + 3'd1 == seq_len) begin
        if (lead == LEAD_E0 && !relaxed && b < E0_SECOND_MIN) bad = 1'b1;
        if (lead == LEAD_ED && b > ED_SECOND_MAX) bad = 1'b1;
        if (lead == LEAD_F0 && !relaxed && b < F0_SECOND_MIN) bad = 1'b1;
        if (lead == LEAD_F4 && b > F4_SECOND_MAX) bad = 1'b1;
      end
      if (!bad) begin
        acc  = {acc[14:0], b[5:0]};
        pend = pend - 2'd1;
        if (pend == 2'd0) begin
          cp  = acc;
          len = seq_len;
          close_sequence();
          if ((cp >= SURR_MIN && cp <= SURR_MAX) || cp > CP_MAX) begin
            bad = 1'b1;
          end else begin
            expect_char(cp, len, STATUS_VALID, fin);
          end
        end else begin
          bad = fin;
        end
      end
    end
    // first error of a buffer: one corrupt beat, then drop to the last byte
    if (bad) begin
      close_sequence();
      dropping = !fin;
      expect_char('0, '0, STATUS_CORRUPT, fin);
    end
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // watch all three channels at each rising edge
  always @(posedge clk) begin
    out_beat_t want;
    if (rst) begin
      relaxed  = 1'b0;
      dropping = 1'b0;
      close_sequence();
      expected_chars.delete();
      fail_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) relaxed = cfg_data;
      if (octet_valid && octet_ready) decode_byte(octet_data.byte_in, octet_data.final_byte);
      if (char_valid && char_ready) begin
        if (expected_chars.size() == 0) begin
          $error("result beat with none expected: code_point %0h status %0h",
                 char_data.code_point, char_data.status);
          fail_count++;
        end else begin
          want = expected_chars.pop_front();
          check_field("code_point", want.code_point, char_data.code_point);
          check_field("byte_count", want.byte_count, char_data.byte_count);
          check_field("status", want.status, char_data.status);
          check_field("buffer_end", want.buffer_end, char_data.buffer_end);
        end
      end
    end
    mismatches      <= fail_count;
    pending_results <= expected_chars.size();
  end

endmodule

### tb/testbench.sv
// testbench: drives byte buffers and relaxed_checks settings into utf8_stream_decoder
// under random idling on both sides; utf8_decode_checker predicts and compares results
// depends on u8dec_pkg, utf8_stream_decoder and utf8_decode_checker
`timescale 1ns / 1ps

module testbench;
  import u8dec_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int PHASE_BYTES    = 66;

  logic      clk         = 1'b0;
  logic      rst         = 1'b1;
  logic      octet_valid = 1'b0;
  logic      octet_ready;
  in_beat_t  octet_data  = '0;
  logic      char_valid;
  logic      char_ready  = 1'b0;
  out_beat_t char_data;
  logic      cfg_valid   = 1'b0;
  logic      cfg_ready;
  logic      cfg_data    = 1'b0;

  int mismatches;
  int pending_results;
  int send_idle = 0;
  int recv_idle = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  utf8_stream_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .octet_valid (octet_valid),
    .octet_ready (octet_ready),
    .octet_data  (octet_data),
    .char_valid  (char_valid),
    .char_ready  (char_ready),
    .char_data   (char_data),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  utf8_decode_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .octet_valid     (octet_valid),
    .octet_ready     (octet_ready),
    .octet_data      (octet_data),
    .char_valid      (char_valid),
    .char_ready      (char_ready),
    .char_data       (char_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  // result side stalls at random
  always @(posedge clk) begin
    char_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // watchdog on cycles where no beat moves on any channel
  always @(posedge clk) begin
    if (rst || (octet_valid && octet_ready) || (char_valid && char_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // one byte beat, with random gaps ahead of it; valid stays up between beats
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(0, 99) < send_idle) begin
      octet_valid <= 1'b0;
      @(posedge clk);
    end
    octet_valid <= 1'b1;
    octet_data  <= '{byte_in: b, final_byte: fin};
    @(posedge clk);
    while (!octet_ready) @(posedge clk);
  endtask

  // wait for every expected result, then let the pipeline settle
  task automatic drain();
    octet_valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_relaxed(input logic v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // second byte, often on a limit of the special leads
  function automatic logic [7:0] second_byte();
    case ($urandom_range(0, 7))
      0:       return CONT_MIN;
      1:       return F4_SECOND_MAX;
      2:       return F0_SECOND_MIN;
      3:       return ED_SECOND_MAX;
      4:       return E0_SECOND_MIN;
      5:       return CONT_MAX;
      default: return 8'($urandom_range(CONT_MIN, CONT_MAX));
    endcase
  endfunction

  function automatic logic [7:0] cont_byte();
    return 8'($urandom_range(CONT_MIN, CONT_MAX));
  endfunction

  // mostly well-formed sequences with random content, some noise and broken ones
  task automatic add_sequence(ref logic [7:0] chunk[$]);
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) begin
      chunk.push_back(8'($urandom_range(0, 127)));
    end else if (pick < 40) begin
      chunk.push_back(8'($urandom_range(LEAD_MIN, LEAD2_MAX)));
      chunk.push_back(second_byte());
    end else if (pick < 60) begin
      case ($urandom_range(0, 3))
        0:       chunk.push_back(LEAD_E0);
        1:       chunk.push_back(LEAD_ED);
        default: chunk.push_back(8'($urandom_range(LEAD2_MAX + 1, LEAD3_MAX)));
      endcase
      chunk.push_back(second_byte());
      chunk.push_back(cont_byte());
    end else if (pick < 78) begin
      case ($urandom_range(0, 3))
        0:       chunk.push_back(LEAD_F0);
        1:       chunk.push_back(LEAD_F4);
        default: chunk.push_back(8'($urandom_range(LEAD_F0 + 1, LEAD_F4 - 1)));
      endcase
      chunk.push_back(second_byte());
      chunk.push_back(cont_byte());
      chunk.push_back(cont_byte());
    end else if (pick < 90) begin
      chunk.push_back(8'($urandom_range(0, 255)));
    end else begin
      // lead followed by a byte outside the continuation range
      chunk.push_back(8'($urandom_range(LEAD_MIN, LEAD_MAX)));
      if ($urandom_range(0, 1)) chunk.push_back(8'($urandom_range(0, 127)));
      else chunk.push_back(8'($urandom_range(8'hC0, 8'hFF)));
    end
  endtask

  initial begin
    logic [7:0] chunk[$];
    int         sent;
    int         count;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed buffers, strict checks
    send_idle = 27;
    recv_idle = 56;
    write_relaxed(1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h7F, 1'b0);
    send_byte(LEAD_MIN, 1'b0);
    send_byte(CONT_MIN, 1'b0);
    send_byte(LEAD2_MAX, 1'b0);
    send_byte(CONT_MAX, 1'b1);
    // overlong after E0: error on the second byte, rest of buffer dropped
    send_byte(LEAD_E0, 1'b0);
    send_byte(8'h9F, 1'b0);
    send_byte(8'h41, 1'b1);
    // surrogate range on the last byte, next byte opens a new buffer
    send_byte(LEAD_ED, 1'b0);
    send_byte(E0_SECOND_MIN, 1'b1);
    // highest scalar value
    send_byte(LEAD_F4, 1'b0);
    send_byte(F4_SECOND_MAX, 1'b0);
    send_byte(CONT_MAX, 1'b0);
    send_byte(CONT_MAX, 1'b0);
    // stray continuation as lead, top byte dropped
    send_byte(CONT_MIN, 1'b0);
    send_byte(8'hFF, 1'b1);
    // sequence cut short by the last byte
    send_byte(8'hE1, 1'b0);
    send_byte(CONT_MIN, 1'b1);
    // bad continuation on the last byte
    send_byte(LEAD_MIN, 1'b0);
    send_byte(8'hC0, 1'b1);
    send_byte(LEAD_F0, 1'b0);
    send_byte(F0_SECOND_MIN, 1'b0);
    send_byte(CONT_MIN, 1'b0);
    send_byte(CONT_MIN, 1'b1);
    drain();

    // random buffers: three idling modes, each with both settings
    for (int phase = 0; phase < 6; phase++) begin
      case (phase / 2)
        0: begin
          send_idle = 27;
          recv_idle = 56;
        end
        1: begin
          send_idle = 56;
          recv_idle = 27;
        end
        default: begin
          send_idle = 0;
          recv_idle = 0;
        end
      endcase
      write_relaxed(phase % 2 == 1);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        chunk.delete();
        count = $urandom_range(1, 4);
        repeat (count) add_sequence(chunk);
        // sometimes cut the buffer short
        if ($urandom_range(0, 9) == 0 && chunk.size() > 1) void'(chunk.pop_back());
        foreach (chunk[i]) send_byte(chunk[i], i == chunk.size() - 1);
        sent += chunk.size();
      end
      drain();
    end

    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_results == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
